FILE: rtl/core/assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LPHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LPHT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define LPHT_ASSERT(lbl, clk, rst_n, prop)
`define LPHT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: rtl/core/lpht_pkg.sv
package lpht_pkg;
    localparam int TABLE_SLOTS_DEF   = 13;
    localparam int MAX_KEY_CHARS_DEF = 32;
    localparam int SUM_W = 13;
    localparam int LEN_W = 7;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    localparam logic CMD_INSERT = 1'b0;

    typedef struct packed {
        logic       command;
        logic [7:0] key_char;
        logic       key_last;
    } lpht_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot_index;
        logic [3:0] probe_count;
    } lpht_out_t;

    typedef struct packed {
        logic             command;
        logic             overflow;
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] len;
    } lpht_desc_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [LEN_W-1:0] idx;
        logic [7:0]       data;
    } lpht_kb_wr_t;
endpackage

FILE: rtl/core/lpht_front.sv
module lpht_front
    import lpht_pkg::*;
#(
    parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lpht_in_t    s_data,
    output logic        push,
    output lpht_desc_t  push_desc,
    output lpht_kb_wr_t kb_wr,
    input  logic        release_key
);
    logic [LEN_W-1:0] len_reg, len_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             ovf_reg, ovf_next;
    logic             cmd_reg, cmd_next;
    logic             bank_reg;
    logic [1:0]       inflight_reg;
    logic             accept, fits;

    assign s_ready = (inflight_reg != 2'd2);
    assign accept  = s_valid && s_ready;
    assign fits    = (len_reg < LEN_W'(MAX_KEY_CHARS));

    always_comb begin
        cmd_next = (len_reg == '0 && !ovf_reg) ? s_data.command : cmd_reg;
        len_next = fits ? len_reg + 1'b1 : len_reg;
        sum_next = fits ? sum_reg + SUM_W'(s_data.key_char) : sum_reg;
        ovf_next = ovf_reg | !fits;
    end

    assign kb_wr.en   = accept && fits;
    assign kb_wr.bank = bank_reg;
    assign kb_wr.idx  = len_reg;
    assign kb_wr.data = s_data.key_char;

    assign push               = accept && s_data.key_last;
    assign push_desc.command  = cmd_next;
    assign push_desc.overflow = ovf_next;
    assign push_desc.sum      = sum_next;
    assign push_desc.len      = len_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
            cmd_reg      <= 1'b0;
            bank_reg     <= 1'b0;
            inflight_reg <= '0;
        end else begin
            if (accept) begin
                if (s_data.key_last) begin
                    len_reg  <= '0;
                    sum_reg  <= '0;
                    ovf_reg  <= 1'b0;
                    cmd_reg  <= 1'b0;
                    bank_reg <= ~bank_reg;
                end else begin
                    len_reg <= len_next;
                    sum_reg <= sum_next;
                    ovf_reg <= ovf_next;
                    cmd_reg <= cmd_next;
                end
            end
            inflight_reg <= inflight_reg + {1'b0, push} - {1'b0, release_key};
        end
    end
endmodule

FILE: rtl/core/lpht_fifo.sv
module lpht_fifo
    import lpht_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  lpht_desc_t push_desc,
    input  logic       pop,
    output logic       not_empty,
    output lpht_desc_t head
);
    lpht_desc_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`include "assert_macros.svh"
    `LPHT_NEVER(a_no_overflow, aclk, aresetn, push && !pop && count_reg == 2'd2)
    `LPHT_NEVER(a_no_underflow, aclk, aresetn, pop && count_reg == 2'd0)
    `LPHT_ASSERT(a_count_range, aclk, aresetn, count_reg <= 2'd2)
endmodule

FILE: rtl/core/lpht_back.sv
module lpht_back
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS   = TABLE_SLOTS_DEF,
    parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  lpht_kb_wr_t kb_wr,
    input  logic        not_empty,
    input  lpht_desc_t  head,
    output logic        pop,
    output logic        release_key,
    output logic        m_valid,
    input  logic        m_ready,
    output lpht_out_t   m_data
);
    localparam int SW       = $clog2(TABLE_SLOTS);
    localparam int PW       = $clog2(TABLE_SLOTS + 1);
    localparam int KB_AW    = $clog2(2 * MAX_KEY_CHARS);
    localparam int SC_AW    = $clog2(TABLE_SLOTS * MAX_KEY_CHARS);
    localparam int RECIP_SH = SUM_W + $clog2(TABLE_SLOTS);
    localparam int RM_W     = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RM_W;
    localparam longint RECIP_M = ((longint'(1) << RECIP_SH) + longint'(TABLE_SLOTS) - 1)
                               / longint'(TABLE_SLOTS);

    typedef enum logic [3:0] {
        IDLE, HASH, REDUCE, META_RD, META_CHK, CMP_RD, CMP_CHK, COPY_RD, COPY_WR, DONE
    } state_t;

    state_t           state_reg;
    lpht_desc_t       desc_reg;
    logic             bank_reg;
    logic [SUM_W-1:0] quot_reg;
    logic [SW-1:0]    idx_reg;
    logic [PW-1:0]    probes_reg;
    logic [LEN_W-1:0] j_reg;
    logic [2:0]       status_reg;
    logic [SW-1:0]    slot_reg;
    logic             m_valid_reg;
    lpht_out_t        m_data_reg;

    logic [7:0]       key_buf [2*MAX_KEY_CHARS];
    logic [7:0]       slot_chars [TABLE_SLOTS*MAX_KEY_CHARS];
    logic [SUM_W-1:0] slot_sum [TABLE_SLOTS];
    logic [LEN_W-1:0] slot_len [TABLE_SLOTS];
    logic             slot_valid_reg [TABLE_SLOTS];

    logic [7:0]       kb_rdata, sc_rdata;
    logic [SUM_W-1:0] meta_sum_q;
    logic [LEN_W-1:0] meta_len_q;
    logic [KB_AW-1:0] kb_waddr, kb_raddr;
    logic [SC_AW-1:0] sc_addr;
    logic [PROD_W-1:0] recip_prod;
    logic [SUM_W-1:0] sum_rem;
    logic [SW-1:0]    idx_wrap;
    logic [PW-1:0]    probes_inc;
    logic             out_free, is_insert, meta_wr, sc_wr;

    assign kb_waddr = kb_wr.bank ? KB_AW'(MAX_KEY_CHARS) + KB_AW'(kb_wr.idx)
                                 : KB_AW'(kb_wr.idx);
    assign kb_raddr = bank_reg ? KB_AW'(MAX_KEY_CHARS) + KB_AW'(j_reg) : KB_AW'(j_reg);
    assign sc_addr  = SC_AW'(idx_reg) * SC_AW'(MAX_KEY_CHARS) + SC_AW'(j_reg);

    // home slot: quotient by reciprocal multiply, then remainder by subtract
    assign recip_prod = PROD_W'(desc_reg.sum) * PROD_W'(RECIP_M);
    assign sum_rem    = desc_reg.sum - SUM_W'(quot_reg * SUM_W'(TABLE_SLOTS));
    assign idx_wrap   = (idx_reg == SW'(TABLE_SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign probes_inc = probes_reg + 1'b1;
    assign is_insert  = (desc_reg.command == CMD_INSERT);
    assign out_free   = !m_valid_reg || m_ready;

    assign pop         = (state_reg == IDLE) && not_empty;
    assign release_key = (state_reg == DONE) && out_free;
    assign meta_wr     = (state_reg == META_CHK) && !slot_valid_reg[idx_reg] && is_insert;
    assign sc_wr       = (state_reg == COPY_WR);
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    always_ff @(posedge aclk) begin
        if (kb_wr.en) key_buf[kb_waddr] <= kb_wr.data;
        kb_rdata <= key_buf[kb_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sc_wr) slot_chars[sc_addr] <= kb_rdata;
        sc_rdata <= slot_chars[sc_addr];
    end

    always_ff @(posedge aclk) begin
        if (meta_wr) begin
            slot_sum[idx_reg] <= desc_reg.sum;
            slot_len[idx_reg] <= desc_reg.len;
        end
        meta_sum_q <= slot_sum[idx_reg];
        meta_len_q <= slot_len[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_SLOTS; i++) slot_valid_reg[i] <= 1'b0;
        end else begin
            // load on release, hold until the transfer
            m_valid_reg <= release_key || (m_valid_reg && !m_ready);
            unique case (state_reg)
                IDLE: begin
                    if (not_empty) begin
                        desc_reg   <= head;
                        probes_reg <= '0;
                        slot_reg   <= '0;
                        if (head.overflow) begin
                            status_reg <= ST_TOO_LONG;
                            state_reg  <= DONE;
                        end else begin
                            state_reg <= HASH;
                        end
                    end
                end
                HASH: begin
                    quot_reg  <= SUM_W'(recip_prod >> RECIP_SH);
                    state_reg <= REDUCE;
                end
                REDUCE: begin
                    idx_reg   <= SW'(sum_rem);
                    state_reg <= META_RD;
                end
                META_RD: state_reg <= META_CHK;
                META_CHK: begin
                    probes_reg <= probes_inc;
                    j_reg      <= '0;
                    if (!slot_valid_reg[idx_reg]) begin
                        if (is_insert) begin
                            slot_valid_reg[idx_reg] <= 1'b1;
                            status_reg <= ST_INSERTED;
                            slot_reg   <= idx_reg;
                            state_reg  <= COPY_RD;
                        end else begin
                            status_reg <= ST_NOT_FOUND;
                            state_reg  <= DONE;
                        end
                    end else if (meta_sum_q == desc_reg.sum && meta_len_q == desc_reg.len) begin
                        state_reg <= CMP_RD;
                    end else if (probes_inc == PW'(TABLE_SLOTS)) begin
                        status_reg <= is_insert ? ST_FULL : ST_NOT_FOUND;
                        state_reg  <= DONE;
                    end else begin
                        idx_reg   <= idx_wrap;
                        state_reg <= META_RD;
                    end
                end
                CMP_RD: state_reg <= CMP_CHK;
                CMP_CHK: begin
                    if (sc_rdata != kb_rdata) begin
                        // mismatch: move on to the next slot, or finish once every slot has been probed
                        if (probes_reg == PW'(TABLE_SLOTS)) begin
                            status_reg <= is_insert ? ST_FULL : ST_NOT_FOUND;
                            state_reg  <= DONE;
                        end else begin
                            idx_reg   <= idx_wrap;
                            state_reg <= META_RD;
                        end
                    end else if (j_reg + 1'b1 == desc_reg.len) begin
                        status_reg <= is_insert ? ST_DUPLICATE : ST_FOUND;
                        slot_reg   <= idx_reg;
                        state_reg  <= DONE;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= CMP_RD;
                    end
                end
                COPY_RD: state_reg <= COPY_WR;
                COPY_WR: begin
                    if (j_reg + 1'b1 == desc_reg.len) begin
                        state_reg <= DONE;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= COPY_RD;
                    end
                end
                DONE: begin
                    if (out_free) begin
                        m_data_reg.status      <= status_reg;
                        m_data_reg.slot_index  <= 4'(slot_reg);
                        m_data_reg.probe_count <= 4'(probes_reg);
                        bank_reg               <= ~bank_reg;
                        state_reg              <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

`include "assert_macros.svh"
    `LPHT_ASSERT(a_probe_bound, aclk, aresetn, probes_reg <= PW'(TABLE_SLOTS) || state_reg == IDLE)
    `LPHT_ASSERT(a_release_loads, aclk, aresetn, release_key |=> m_valid_reg)
    `LPHT_NEVER(a_cmp_in_key, aclk, aresetn, state_reg == CMP_RD && j_reg >= desc_reg.len)
endmodule

FILE: rtl/core/linear_probe_hash_table_unit.sv
// Linear-probing hash table keyed by byte strings. Characters are taken one per
// cycle while s_ready is high; a key's command is sampled with its first
// character, and one result (status, slot, probe count) follows each key's last
// character. Keys queue two deep behind the character front end, so the next
// key streams in while the table works. A key's character sum is reduced to a
// home slot (a reciprocal multiply, then a subtract); then each slot examined
// and each character compared or copied into the table takes a read state and
// a check or write state, because every slot and character access goes through a
// registered memory read port. The key is taken in IDLE, the result handed off in DONE.
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS   = TABLE_SLOTS_DEF,
    parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lpht_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output lpht_out_t m_data
);
    logic        push, pop, not_empty, release_key;
    lpht_desc_t  push_desc, head;
    lpht_kb_wr_t kb_wr;

    lpht_front #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .push, .push_desc, .kb_wr, .release_key
    );

    lpht_fifo u_fifo (
        .aclk, .aresetn, .push, .push_desc, .pop, .not_empty, .head
    );

    lpht_back #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_KEY_CHARS(MAX_KEY_CHARS)) u_back (
        .aclk, .aresetn, .kb_wr, .not_empty, .head, .pop, .release_key,
        .m_valid, .m_ready, .m_data
    );
endmodule
